### src/mfd_pkg.sv
// Shared types and constants of the motor feedback frame decoder.
package mfd_pkg;

    // Bus geometry
    localparam int unsigned NUM_MOTORS = 4;
    localparam int unsigned MOTOR_W    = 2;
    localparam int unsigned OCTET_W    = 8;
    localparam int unsigned RATIO_W    = 8;

    // Stored record widths
    localparam int unsigned VEL_W   = 17;
    localparam int unsigned POS_W   = 32;
    localparam int unsigned ANGLE_W = 45;

    // Default number of fraction bits of the angle
    localparam int unsigned ANGLE_FRAC_BITS_DEF = 16;

    // Function codes and byte values
    localparam logic [OCTET_W-1:0] CODE_VELOCITY = 8'h35;
    localparam logic [OCTET_W-1:0] CODE_POSITION = 8'h36;
    localparam logic [OCTET_W-1:0] CODE_STATUS   = 8'h3A;
    localparam logic [OCTET_W-1:0] SIGN_NEGATIVE = 8'h01;
    localparam logic [OCTET_W-1:0] ADDR_FIRST    = 8'h01;
    localparam logic [OCTET_W-1:0] ADDR_LAST     = 8'h04;
    localparam int unsigned        REACHED_BIT   = 1;

    // Minimum byte counts per function code
    localparam logic [OCTET_W-1:0] MIN_LEN_VELOCITY = 8'd6;
    localparam logic [OCTET_W-1:0] MIN_LEN_POSITION = 8'd8;
    localparam logic [OCTET_W-1:0] MIN_LEN_STATUS   = 8'd4;

    // Angle scale: 360 / 3200 reduces exactly to 9 / 80
    localparam int unsigned ANGLE_SCALE = 9;
    localparam int unsigned DEN_UNIT    = 80;
    // |position| <= 2^31, times 9 fits 35 bits
    localparam int unsigned PROD_W = 35;
    // 80 * 255 = 20400 fits 15 bits
    localparam int unsigned DEN_W  = 15;
    // Divisor is at least 80 > 2^6 - 1, so the top 6 quotient bits are zero
    localparam int unsigned DIV_SKIP = 6;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIVIDE,
        ST_FINISH
    } t_state;

    // Kind of update a frame made
    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_VELOCITY = 2'd1,
        KIND_POSITION = 2'd2,
        KIND_STATUS   = 2'd3
    } t_kind;

endpackage

### src/mfd_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, leading zero bits skipped.
module mfd_div #(
    parameter int unsigned NUM_W = mfd_pkg::PROD_W + mfd_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int unsigned DEN_W = mfd_pkg::DEN_W,
    parameter int unsigned SKIP  = mfd_pkg::DIV_SKIP
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int unsigned STEPS = NUM_W - SKIP;
    localparam int unsigned CNT_W = $clog2(STEPS + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quot;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    // Trial subtract of the shifted remainder
    assign trial = {r_rem, r_quot[NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: top SKIP numerator bits preload the remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= DEN_W'(i_num[NUM_W-1:NUM_W-SKIP]);
            r_quot <= i_num << SKIP;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quot <= {r_quot[NUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### src/motor_feedback_frame_decoder_top.sv
// Top level of the motor feedback frame decoder: decode, record store, angle sequencer.
//
//   channel   direction  handshake            payload
//   frame in  input      i_valid / o_stall    i_frame_length, i_address_octet .. i_payload_octet6
//   record    output     o_valid / i_stall    o_frame_accepted .. o_position_reached
//   config    input      i_cfg_we             i_cfg_index, i_cfg_data (gear ratios)
//
// A position frame goes from transfer through the load, divide and finish states; its result
// is set by the 29 + ANGLE_FRAC_BITS steps of the bit-serial angle divider, and other frames go
// straight to the finish state. The next frame can transfer in the cycle after the result is loaded.
// One frame is in work at a time; o_stall is high from transfer until the result is loaded.
// The result register holds while i_stall is high; a finished frame waits for it to empty.
// Synchronous active-low reset clears all stored records and sets every ratio to 1.
module motor_feedback_frame_decoder_top #(
    parameter int unsigned ANGLE_FRAC_BITS = mfd_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // frame in
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_frame_length,
    input  logic [7:0]  i_address_octet,
    input  logic [7:0]  i_function_octet,
    input  logic [7:0]  i_payload_octet2,
    input  logic [7:0]  i_payload_octet3,
    input  logic [7:0]  i_payload_octet4,
    input  logic [7:0]  i_payload_octet5,
    input  logic [7:0]  i_payload_octet6,
    // record out
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_frame_accepted,
    output logic [1:0]  o_motor_number,
    output logic [1:0]  o_update_kind,
    output logic signed [16:0] o_motor_velocity,
    output logic signed [31:0] o_motor_position,
    output logic signed [44:0] o_motor_angle_q16,
    output logic        o_position_reached
);

    localparam int unsigned NUM_W   = mfd_pkg::PROD_W + ANGLE_FRAC_BITS;
    localparam int unsigned VEL_W   = mfd_pkg::VEL_W;
    localparam int unsigned POS_W   = mfd_pkg::POS_W;
    localparam int unsigned ANGLE_W = mfd_pkg::ANGLE_W;
    localparam int unsigned MOTOR_W = mfd_pkg::MOTOR_W;
    localparam int unsigned RATIO_W = mfd_pkg::RATIO_W;
    localparam int unsigned DEN_W   = mfd_pkg::DEN_W;
    localparam int unsigned PROD_W  = mfd_pkg::PROD_W;
    localparam int unsigned NM      = mfd_pkg::NUM_MOTORS;

    // Registers
    mfd_pkg::t_state     r_state;
    mfd_pkg::t_state     n_state;
    logic [RATIO_W-1:0]  r_ratio [NM];
    logic [VEL_W-1:0]    r_vel_st [NM];
    logic [POS_W-1:0]    r_pos_st [NM];
    logic [ANGLE_W-1:0]  r_ang_st [NM];
    logic                r_reach_st [NM];

    logic                r_acc;
    logic [MOTOR_W-1:0]  r_motor;
    mfd_pkg::t_kind      r_kind;
    logic [VEL_W-1:0]    r_vel_new;
    logic [POS_W-1:0]    r_pos_new;
    logic                r_reach_new;
    logic [RATIO_W-1:0]  r_ratio_eff;

    logic                r_out_valid;
    logic                r_out_acc;
    logic [MOTOR_W-1:0]  r_out_motor;
    logic [1:0]          r_out_kind;
    logic [VEL_W-1:0]    r_out_vel;
    logic [POS_W-1:0]    r_out_pos;
    logic [ANGLE_W-1:0]  r_out_ang;
    logic                r_out_reach;

    // Combinational
    logic                in_xfer;
    logic                out_free;
    logic                finish_go;
    logic                div_start;
    logic                div_done;
    logic [NUM_W-1:0]    div_quot;
    logic [NUM_W-1:0]    div_num;
    logic [DEN_W-1:0]    div_den;
    logic [POS_W-1:0]    pos_mag;
    logic [PROD_W-1:0]   pos_prod;
    logic [ANGLE_W-1:0]  quot_ext;
    logic [ANGLE_W-1:0]  ang_new;

    logic                in_ok;
    logic [MOTOR_W-1:0]  in_motor;
    mfd_pkg::t_kind      in_kind;
    logic                in_neg;
    logic [15:0]         in_spd;
    logic [POS_W-1:0]    in_raw;
    logic [RATIO_W-1:0]  in_ratio;

    logic [VEL_W-1:0]    rec_vel;
    logic [POS_W-1:0]    rec_pos;
    logic [ANGLE_W-1:0]  rec_ang;
    logic                rec_reach;

    assign in_xfer  = i_valid && (r_state == mfd_pkg::ST_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != mfd_pkg::ST_IDLE);

    // Frame decode; clamping the length to 8 leaves every length test unchanged
    assign in_ok = (i_frame_length != '0)
                && (i_address_octet >= mfd_pkg::ADDR_FIRST)
                && (i_address_octet <= mfd_pkg::ADDR_LAST);
    assign in_motor = MOTOR_W'(i_address_octet - mfd_pkg::ADDR_FIRST);
    assign in_neg   = (i_payload_octet2 == mfd_pkg::SIGN_NEGATIVE);
    assign in_spd   = {i_payload_octet3, i_payload_octet4};
    assign in_raw   = {i_payload_octet3, i_payload_octet4, i_payload_octet5, i_payload_octet6};
    assign in_ratio = (r_ratio[in_motor] == '0) ? RATIO_W'(1) : r_ratio[in_motor];

    always_comb begin
        in_kind = mfd_pkg::KIND_NONE;
        if (in_ok) begin
            priority if (i_function_octet == mfd_pkg::CODE_VELOCITY) begin
                if (i_frame_length >= mfd_pkg::MIN_LEN_VELOCITY) in_kind = mfd_pkg::KIND_VELOCITY;
            end else if (i_function_octet == mfd_pkg::CODE_POSITION) begin
                if (i_frame_length >= mfd_pkg::MIN_LEN_POSITION) in_kind = mfd_pkg::KIND_POSITION;
            end else if (i_function_octet == mfd_pkg::CODE_STATUS) begin
                if (i_frame_length >= mfd_pkg::MIN_LEN_STATUS) in_kind = mfd_pkg::KIND_STATUS;
            end else begin
                in_kind = mfd_pkg::KIND_NONE;
            end
        end
    end

    // Capture the decoded frame at transfer
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_acc       <= in_ok;
            r_motor     <= in_motor;
            r_kind      <= in_kind;
            r_vel_new   <= in_neg ? (VEL_W'(0) - {1'b0, in_spd}) : {1'b0, in_spd};
            r_pos_new   <= in_neg ? (POS_W'(0) - in_raw) : in_raw;
            r_reach_new <= i_payload_octet2[mfd_pkg::REACHED_BIT];
            r_ratio_eff <= in_ratio;
        end
    end

    // Divider operands: |pos| * 9 * 2^F over ratio * 80
    assign pos_mag  = r_pos_new[POS_W-1] ? (POS_W'(0) - r_pos_new) : r_pos_new;
    assign pos_prod = PROD_W'(pos_mag) * PROD_W'(mfd_pkg::ANGLE_SCALE);
    assign div_num  = NUM_W'(pos_prod) << ANGLE_FRAC_BITS;
    assign div_den  = DEN_W'(r_ratio_eff) * DEN_W'(mfd_pkg::DEN_UNIT);

    mfd_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .SKIP  (mfd_pkg::DIV_SKIP)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Fit the quotient to the angle width
    generate
        if (NUM_W >= ANGLE_W) begin : g_quot_cut
            assign quot_ext = div_quot[ANGLE_W-1:0];
        end else begin : g_quot_ext
            assign quot_ext = ANGLE_W'(div_quot);
        end
    endgenerate

    // Angle takes the sign of the position, truncated toward zero
    assign ang_new = r_pos_new[POS_W-1] ? (ANGLE_W'(0) - quot_ext) : quot_ext;

    // Record of the addressed motor after this frame
    always_comb begin
        rec_vel   = r_vel_st[r_motor];
        rec_pos   = r_pos_st[r_motor];
        rec_ang   = r_ang_st[r_motor];
        rec_reach = r_reach_st[r_motor];
        unique case (r_kind)
            mfd_pkg::KIND_VELOCITY: rec_vel = r_vel_new;
            mfd_pkg::KIND_POSITION: begin
                rec_pos = r_pos_new;
                rec_ang = ang_new;
            end
            mfd_pkg::KIND_STATUS:   rec_reach = r_reach_new;
            mfd_pkg::KIND_NONE:     ;
        endcase
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        finish_go = 1'b0;
        unique case (r_state)
            mfd_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_state = (in_kind == mfd_pkg::KIND_POSITION) ? mfd_pkg::ST_LOAD
                                                                  : mfd_pkg::ST_FINISH;
                end
            end
            mfd_pkg::ST_LOAD: begin
                div_start = 1'b1;
                n_state   = mfd_pkg::ST_DIVIDE;
            end
            mfd_pkg::ST_DIVIDE: begin
                if (div_done) n_state = mfd_pkg::ST_FINISH;
            end
            mfd_pkg::ST_FINISH: begin
                if (out_free) begin
                    finish_go = 1'b1;
                    n_state   = mfd_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Gear ratio registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NM; i++) r_ratio[i] <= RATIO_W'(1);
        end else if (i_cfg_we) begin
            r_ratio[i_cfg_index] <= i_cfg_data;
        end
    end

    // Feedback record store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NM; i++) begin
                r_vel_st[i]   <= '0;
                r_pos_st[i]   <= '0;
                r_ang_st[i]   <= '0;
                r_reach_st[i] <= 1'b0;
            end
        end else if (finish_go && r_acc) begin
            r_vel_st[r_motor]   <= rec_vel;
            r_pos_st[r_motor]   <= rec_pos;
            r_ang_st[r_motor]   <= rec_ang;
            r_reach_st[r_motor] <= rec_reach;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish_go) begin
            r_out_acc   <= r_acc;
            r_out_motor <= r_acc ? r_motor : '0;
            r_out_kind  <= r_kind;
            r_out_vel   <= r_acc ? rec_vel : '0;
            r_out_pos   <= r_acc ? rec_pos : '0;
            r_out_ang   <= r_acc ? rec_ang : '0;
            r_out_reach <= r_acc ? rec_reach : 1'b0;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_frame_accepted   = r_out_acc;
    assign o_motor_number     = r_out_motor;
    assign o_update_kind      = r_out_kind;
    assign o_motor_velocity   = r_out_vel;
    assign o_motor_position   = r_out_pos;
    assign o_motor_angle_q16  = r_out_ang;
    assign o_position_reached = r_out_reach;

    // A new result only comes out of the finish step
    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == mfd_pkg::ST_FINISH))
        else $error("result appeared outside finish step");

    // Divider runs only for position frames
    a_divide_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mfd_pkg::ST_DIVIDE) |-> (r_kind == mfd_pkg::KIND_POSITION))
        else $error("divider busy for a non-position frame");

    // Divider completion only while the sequencer waits for it
    a_done_in_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == mfd_pkg::ST_DIVIDE))
        else $error("divider done outside divide state");

    // Rejected frames carry an all-zero record
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_frame_accepted) |-> (o_update_kind == mfd_pkg::KIND_NONE
            && o_motor_number == '0 && o_motor_velocity == '0 && o_motor_position == '0
            && o_motor_angle_q16 == '0 && !o_position_reached))
        else $error("rejected frame with nonzero record");

    // Position and angle stay in step: zero position means zero angle
    a_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_motor_position == '0) |-> (o_motor_angle_q16 == '0))
        else $error("nonzero angle for zero position");

endmodule

### dv/tb.sv
// Testbench of the motor feedback frame decoder: directed and random frames, behavioral check.
module tb;

    localparam int unsigned ANGLE_FRAC    = 16;
    localparam int unsigned RESET_CYCLES  = 11;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned TAIL_CYCLES   = 33 + ANGLE_FRAC + 10;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned PHASE_FRAMES  = 115;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam logic [7:0]  FRAME_MAX_LEN = 8'd8;
    localparam int unsigned NUM_MOTORS    = mfd_pkg::NUM_MOTORS;

    localparam longint unsigned STEPS_PER_REV = 3200;
    localparam longint unsigned DEG_PER_REV   = 360;

    // Register map of the configuration port
    typedef enum logic [1:0] {
        RATIO_MOTOR_ONE,
        RATIO_MOTOR_TWO,
        RATIO_MOTOR_THREE,
        RATIO_MOTOR_FOUR
    } t_ratio_index;

    typedef struct {
        logic [7:0] length;
        logic [7:0] address;
        logic [7:0] code;
        logic [7:0] octet2;
        logic [7:0] octet3;
        logic [7:0] octet4;
        logic [7:0] octet5;
        logic [7:0] octet6;
    } t_frame;

    typedef struct {
        logic               accepted;
        logic [1:0]         motor;
        mfd_pkg::t_kind     kind;
        logic signed [16:0] velocity;
        logic signed [31:0] position;
        logic signed [44:0] angle;
        logic               reached;
    } t_feedback_record;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_cfg_we         = 1'b0;
    logic [1:0]  i_cfg_index      = RATIO_MOTOR_ONE;
    logic [7:0]  i_cfg_data       = 8'd1;
    logic        i_valid          = 1'b0;
    logic        i_stall          = 1'b0;
    logic [7:0]  i_frame_length   = '0;
    logic [7:0]  i_address_octet  = '0;
    logic [7:0]  i_function_octet = '0;
    logic [7:0]  i_payload_octet2 = '0;
    logic [7:0]  i_payload_octet3 = '0;
    logic [7:0]  i_payload_octet4 = '0;
    logic [7:0]  i_payload_octet5 = '0;
    logic [7:0]  i_payload_octet6 = '0;
    logic        o_stall;
    logic        o_valid;
    logic        o_frame_accepted;
    logic [1:0]  o_motor_number;
    logic [1:0]  o_update_kind;
    logic signed [16:0] o_motor_velocity;
    logic signed [31:0] o_motor_position;
    logic signed [44:0] o_motor_angle_q16;
    logic        o_position_reached;

    // Behavioral copy of the decoder state
    logic [7:0]         gear_ratio   [NUM_MOTORS];
    logic signed [16:0] rec_velocity [NUM_MOTORS];
    logic signed [31:0] rec_position [NUM_MOTORS];
    logic signed [44:0] rec_angle    [NUM_MOTORS];
    logic               rec_reached  [NUM_MOTORS];

    t_feedback_record expected_records[$];

    int unsigned cycle_count      = 0;
    int unsigned error_count      = 0;
    int unsigned hold_requests    = 0;
    int unsigned holds_served     = 0;
    int unsigned hold_run         = 0;
    int unsigned stall_run        = 0;
    bit          sender_idle_on   = 1'b1;
    bit          receiver_idle_on = 1'b1;

    motor_feedback_frame_decoder_top #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_frame_length     (i_frame_length),
        .i_address_octet    (i_address_octet),
        .i_function_octet   (i_function_octet),
        .i_payload_octet2   (i_payload_octet2),
        .i_payload_octet3   (i_payload_octet3),
        .i_payload_octet4   (i_payload_octet4),
        .i_payload_octet5   (i_payload_octet5),
        .i_payload_octet6   (i_payload_octet6),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_frame_accepted   (o_frame_accepted),
        .o_motor_number     (o_motor_number),
        .o_update_kind      (o_update_kind),
        .o_motor_velocity   (o_motor_velocity),
        .o_motor_position   (o_motor_position),
        .o_motor_angle_q16  (o_motor_angle_q16),
        .o_position_reached (o_position_reached)
    );

    always #10 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Idle length: mostly short, a few long
    function automatic int unsigned idle_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return $urandom_range(1, 3);
        if (pick < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Angle in Q16 degrees, truncated toward zero
    function automatic logic [44:0] angle_from_steps(logic [31:0] steps, logic [7:0] ratio);
        logic [31:0]     abs_steps;
        longint unsigned mag;
        longint unsigned den;
        longint unsigned quo;
        abs_steps = steps[31] ? 32'd0 - steps : steps;
        mag = 64'(abs_steps);
        den = STEPS_PER_REV * ((ratio == 8'd0) ? 64'd1 : 64'(ratio));
        quo = ((mag * DEG_PER_REV) << ANGLE_FRAC) / den;
        if (steps[31]) quo = 64'd0 - quo;
        return quo[44:0];
    endfunction

    // Decode one frame, update the stored records, return the expected record
    function automatic t_feedback_record decode_frame(t_frame f);
        t_feedback_record r;
        logic [7:0]       len;
        logic [1:0]       m;
        logic             neg;
        logic [16:0]      speed;
        logic [31:0]      steps;
        r.accepted = 1'b0;
        r.motor    = '0;
        r.kind     = mfd_pkg::KIND_NONE;
        r.velocity = '0;
        r.position = '0;
        r.angle    = '0;
        r.reached  = 1'b0;
        len = (f.length > FRAME_MAX_LEN) ? FRAME_MAX_LEN : f.length;
        if (len == 8'd0 || f.address < mfd_pkg::ADDR_FIRST || f.address > mfd_pkg::ADDR_LAST)
            return r;
        m   = 2'(f.address - mfd_pkg::ADDR_FIRST);
        neg = (f.octet2 == mfd_pkg::SIGN_NEGATIVE);
        if (f.code == mfd_pkg::CODE_VELOCITY) begin
            if (len >= mfd_pkg::MIN_LEN_VELOCITY) begin
                speed = {1'b0, f.octet3, f.octet4};
                if (neg) speed = 17'd0 - speed;
                rec_velocity[m] = speed;
                r.kind = mfd_pkg::KIND_VELOCITY;
            end
        end else if (f.code == mfd_pkg::CODE_POSITION) begin
            if (len >= mfd_pkg::MIN_LEN_POSITION) begin
                steps = {f.octet3, f.octet4, f.octet5, f.octet6};
                if (neg) steps = 32'd0 - steps;
                rec_position[m] = steps;
                rec_angle[m]    = angle_from_steps(steps, gear_ratio[m]);
                r.kind = mfd_pkg::KIND_POSITION;
            end
        end else if (f.code == mfd_pkg::CODE_STATUS) begin
            if (len >= mfd_pkg::MIN_LEN_STATUS) begin
                rec_reached[m] = f.octet2[mfd_pkg::REACHED_BIT];
                r.kind = mfd_pkg::KIND_STATUS;
            end
        end
        r.accepted = 1'b1;
        r.motor    = m;
        r.velocity = rec_velocity[m];
        r.position = rec_position[m];
        r.angle    = rec_angle[m];
        r.reached  = rec_reached[m];
        return r;
    endfunction

    function automatic t_frame make_frame(logic [7:0] len, logic [7:0] addr, logic [7:0] code,
                                          logic [7:0] sign, logic [31:0] value);
        t_frame f;
        f.length  = len;
        f.address = addr;
        f.code    = code;
        f.octet2  = sign;
        {f.octet3, f.octet4, f.octet5, f.octet6} = value;
        return f;
    endfunction

    // Mostly well-formed frames with random content, the rest noise
    function automatic t_frame random_frame();
        t_frame      f;
        logic [7:0]  min_len;
        logic [31:0] value;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            value = $urandom;
            return make_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), value);
        end
        pick = $urandom_range(0, 2);
        if (pick == 0) begin
            f.code = mfd_pkg::CODE_VELOCITY;
            min_len = mfd_pkg::MIN_LEN_VELOCITY;
        end else if (pick == 1) begin
            f.code = mfd_pkg::CODE_POSITION;
            min_len = mfd_pkg::MIN_LEN_POSITION;
        end else begin
            f.code = mfd_pkg::CODE_STATUS;
            min_len = mfd_pkg::MIN_LEN_STATUS;
        end
        f.address = 8'($urandom_range(mfd_pkg::ADDR_FIRST, mfd_pkg::ADDR_LAST));
        pick = $urandom_range(0, 99);
        if (pick < 10)      f.length = 8'($urandom_range(1, min_len - 1));
        else if (pick < 85) f.length = 8'($urandom_range(min_len, FRAME_MAX_LEN));
        else                f.length = 8'($urandom_range(FRAME_MAX_LEN + 1, 255));
        pick = $urandom_range(0, 99);
        if (pick < 40)      f.octet2 = mfd_pkg::SIGN_NEGATIVE;
        else if (pick < 50) f.octet2 = 8'h00;
        else                f.octet2 = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 8)       value = 32'hFFFF_FFFF;
        else if (pick < 14) value = 32'h0000_0000;
        else                value = $urandom;
        {f.octet3, f.octet4, f.octet5, f.octet6} = value;
        return f;
    endfunction

    function automatic logic [7:0] random_ratio();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) return 8'd1;
        if (pick < 20) return 8'd255;
        return 8'($urandom_range(1, 255));
    endfunction

    // One frame transfer; valid stays high afterwards for a back-to-back frame
    task automatic send_frame(input t_frame f);
        int unsigned gap;
        gap = (sender_idle_on && $urandom_range(0, 2) == 0) ? idle_length() : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_frame_length   <= f.length;
        i_address_octet  <= f.address;
        i_function_octet <= f.code;
        i_payload_octet2 <= f.octet2;
        i_payload_octet3 <= f.octet3;
        i_payload_octet4 <= f.octet4;
        i_payload_octet5 <= f.octet5;
        i_payload_octet6 <= f.octet6;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_records.push_back(decode_frame(f));
    endtask

    // Stop offering and wait until every record is back
    task automatic drain_records();
        i_valid <= 1'b0;
        while (expected_records.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all four gear ratios, one per cycle
    task automatic set_ratios(input logic [7:0] r0, input logic [7:0] r1,
                              input logic [7:0] r2, input logic [7:0] r3);
        logic [7:0] ratios [NUM_MOTORS];
        ratios = '{r0, r1, r2, r3};
        for (int k = 0; k < NUM_MOTORS; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= t_ratio_index'(k);
            i_cfg_data  <= ratios[k];
            @(posedge i_clk);
            gear_ratio[k] = ratios[k];
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_rejected_frames();
        send_frame(make_frame(8'd0, mfd_pkg::ADDR_FIRST, mfd_pkg::CODE_VELOCITY, 8'h00,
                              32'h1234_5678));
        send_frame(make_frame(8'd8, 8'd0, mfd_pkg::CODE_POSITION, 8'h00, 32'h1234_5678));
        send_frame(make_frame(8'd8, mfd_pkg::ADDR_LAST + 8'd1, mfd_pkg::CODE_STATUS, 8'hFF,
                              32'h0));
        send_frame(make_frame(8'd255, 8'd255, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
        drain_records();
    endtask

    task automatic test_velocity_frames();
        send_frame(make_frame(8'd6, 8'd1, mfd_pkg::CODE_VELOCITY, 8'h00, 32'hFFFF_0000));
        send_frame(make_frame(8'd255, 8'd2, mfd_pkg::CODE_VELOCITY, mfd_pkg::SIGN_NEGATIVE,
                              32'hFFFF_FFFF));
        // one byte short of a velocity
        send_frame(make_frame(8'd5, 8'd3, mfd_pkg::CODE_VELOCITY, 8'h00, 32'h1234_0000));
        // sign byte other than exactly one stays positive
        send_frame(make_frame(8'd6, 8'd4, mfd_pkg::CODE_VELOCITY, 8'h03, 32'h0100_0000));
        drain_records();
    endtask

    task automatic test_position_frames();
        send_frame(make_frame(8'd8, 8'd1, mfd_pkg::CODE_POSITION, 8'h00, 32'h7FFF_FFFF));
        // negating the most negative value wraps onto itself
        send_frame(make_frame(8'd8, 8'd2, mfd_pkg::CODE_POSITION, mfd_pkg::SIGN_NEGATIVE,
                              32'h8000_0000));
        send_frame(make_frame(8'd9, 8'd3, mfd_pkg::CODE_POSITION, mfd_pkg::SIGN_NEGATIVE,
                              32'hFFFF_FFFF));
        send_frame(make_frame(8'd8, 8'd4, mfd_pkg::CODE_POSITION, 8'h00, 32'hFFFF_FFFF));
        send_frame(make_frame(8'd7, 8'd1, mfd_pkg::CODE_POSITION, 8'h00, 32'h1234_5678));
        send_frame(make_frame(8'd200, 8'd2, mfd_pkg::CODE_POSITION, mfd_pkg::SIGN_NEGATIVE,
                              32'h0));
        drain_records();
    endtask

    task automatic test_status_and_unknown();
        send_frame(make_frame(8'd4, 8'd1, mfd_pkg::CODE_STATUS, 8'h02, 32'h0));
        send_frame(make_frame(8'd3, 8'd2, mfd_pkg::CODE_STATUS, 8'hFF, 32'h0));
        send_frame(make_frame(8'd4, 8'd3, mfd_pkg::CODE_STATUS, 8'hFD, 32'hFFFF_FFFF));
        send_frame(make_frame(8'd8, 8'd4, mfd_pkg::CODE_STATUS, 8'hFF, 32'h0));
        send_frame(make_frame(8'd8, 8'd2, 8'h00, mfd_pkg::SIGN_NEGATIVE, 32'hFFFF_FFFF));
        send_frame(make_frame(8'd8, 8'd3, 8'hFF, 8'h00, 32'h7FFF_FFFF));
        send_frame(make_frame(8'd8, 8'd1, 8'h37, mfd_pkg::SIGN_NEGATIVE, 32'h8000_0000));
        drain_records();
    endtask

    // Extreme positions under extreme ratios, a zero ratio among them
    task automatic test_ratio_extremes();
        logic [7:0] settings [3][NUM_MOTORS];
        logic [7:0] addr;
        settings = '{'{8'd255, 8'd255, 8'd255, 8'd255},
                     '{8'd1, 8'd255, 8'd0, 8'd128},
                     '{8'd254, 8'd2, 8'd1, 8'd255}};
        for (int s = 0; s < 3; s++) begin
            set_ratios(settings[s][0], settings[s][1], settings[s][2], settings[s][3]);
            for (int k = 0; k < NUM_MOTORS; k++) begin
                addr = mfd_pkg::ADDR_FIRST + 8'(k);
                send_frame(make_frame(8'd8, addr, mfd_pkg::CODE_POSITION, 8'h00,
                                      32'h7FFF_FFFF));
                send_frame(make_frame(8'd8, addr, mfd_pkg::CODE_POSITION,
                                      mfd_pkg::SIGN_NEGATIVE, 32'h8000_0000));
                send_frame(make_frame(8'd8, addr, mfd_pkg::CODE_POSITION,
                                      8'($urandom_range(0, 1)), $urandom));
            end
            drain_records();
        end
    endtask

    // Receiver holds off for a long stretch while frames keep coming
    task automatic test_backpressure();
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        hold_requests    = hold_requests + 1;
        repeat (8) send_frame(random_frame());
        drain_records();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++) begin
            sender_idle_on   = (phase != 0 && phase != 3);
            receiver_idle_on = (phase != 0 && phase != 2);
            set_ratios(random_ratio(), random_ratio(), random_ratio(), random_ratio());
            repeat (PHASE_FRAMES) send_frame(random_frame());
            drain_records();
        end
    endtask

    // Receiver stall: long hold on request, else random idling
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served <= hold_requests;
            hold_run     <= HOLD_CYCLES - 1;
            i_stall      <= 1'b1;
        end else if (hold_run != 0) begin
            hold_run <= hold_run - 1;
            i_stall  <= 1'b1;
        end else if (stall_run != 0) begin
            stall_run <= stall_run - 1;
            i_stall   <= 1'b1;
        end else if (receiver_idle_on && $urandom_range(0, 3) == 0) begin
            stall_run <= idle_length() - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // Compare each record transfer with the oldest expectation
    always @(posedge i_clk) begin : record_check
        t_feedback_record want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_records.size() == 0) begin
                $error("record transfer with no frame outstanding");
                error_count++;
            end else begin
                want = expected_records.pop_front();
                check_field("frame_accepted", 64'(want.accepted), 64'(o_frame_accepted));
                check_field("motor_number", 64'(want.motor), 64'(o_motor_number));
                check_field("update_kind", 64'(want.kind), 64'(o_update_kind));
                check_field("motor_velocity", 64'(want.velocity), 64'(o_motor_velocity));
                check_field("motor_position", 64'(want.position), 64'(o_motor_position));
                check_field("motor_angle_q16", 64'(want.angle), 64'(o_motor_angle_q16));
                check_field("position_reached", 64'(want.reached), 64'(o_position_reached));
            end
        end
    end

    initial begin
        for (int k = 0; k < NUM_MOTORS; k++) begin
            gear_ratio[k]   = 8'd1;
            rec_velocity[k] = '0;
            rec_position[k] = '0;
            rec_angle[k]    = '0;
            rec_reached[k]  = 1'b0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_rejected_frames();
        test_velocity_frames();
        test_position_frames();
        test_status_and_unknown();
        test_ratio_extremes();
        test_backpressure();
        test_random_traffic();

        drain_records();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_records.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
src/mfd_pkg.sv
src/mfd_div.sv
src/motor_feedback_frame_decoder_top.sv
dv/tb.sv
